// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the square image rotator.
// Depends on nothing; each macro expects a clock and reset of the usual names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that two conditions never hold in the same cycle.
`define ASSERT_NEVER_BOTH(label, a, b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ((a) |-> !(b))) else $error(msg);

`endif

// ===== hw/rtl/sqr_rot_pkg.sv =====
// Package of the square image rotator: widths, character codes, view codes,
// register indexes and the control struct between controller and pixel memory.
package sqr_rot_pkg;

   localparam int DEF_MAX_SIDE = 16;
   localparam int SIDE_W = 5;
   localparam int PIX_W = 8;
   localparam int MIN_SIDE = 2;
   localparam int RESET_SIDE = 2;

   localparam logic [PIX_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [PIX_W-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] VIEW_ORIG = 2'd0;
   localparam logic [1:0] VIEW_ROT90 = 2'd1;
   localparam logic [1:0] VIEW_ROT270 = 2'd2;
   localparam logic [1:0] VIEW_DIAMOND = 2'd3;

   localparam logic REG_SIDE = 1'b0;
   localparam logic REG_VIEW = 1'b1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic blank;
      logic row_end;
      logic img_end;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/sqr_rot_mem.sv =====
// Pixel memory of the square image rotator: one write port, one registered read port.
// Depends on sqr_rot_pkg for the pixel width and the control struct.
module sqr_rot_mem import sqr_rot_pkg::*; #(
   parameter int MAX_SIDE = DEF_MAX_SIDE,
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
   input  logic             clock,
   input  mem_ctl_type      ctl,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] store_ff [MAX_SIDE * MAX_SIDE];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sqr_rot_ctrl.sv =====
// Controller of the square image rotator: registers, load and output counters,
// and the mapping of each view position to a pixel address. Uses sqr_rot_pkg.
module sqr_rot_ctrl import sqr_rot_pkg::*; #(
   parameter int MAX_SIDE = DEF_MAX_SIDE,
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              req_action,
   input  logic [PIX_W-1:0]  req_pixel_in,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIDE_W-1:0] csr_wdata,
   output mem_ctl_type       ctl,
   output logic [AW-1:0]     wr_addr,
   output logic [AW-1:0]     rd_addr
);

   localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int OW = $clog2(2 * MAX_SIDE);
   localparam int DW = OW + 2;

   logic [SIDE_W-1:0] side_ff, side_in, side_wr;
   logic [1:0]        view_ff, view_in;
   logic              loaded_ff, loaded_in;
   logic [CW-1:0]     load_row_ff, load_row_in, load_col_ff, load_col_in;
   logic [OW-1:0]     out_row_ff, out_row_in, out_col_ff, out_col_in;

   logic [OW-1:0]        n1, dim, cur_r, cur_c;
   logic signed [DW-1:0] da, db;
   logic [DW-2:0]        ha, hb;
   logic [CW-1:0]        pr, pc;
   logic                 blank, skip, do_load, do_read;

   assign skip = (req_pixel_in == CHAR_SPACE) || (req_pixel_in == CHAR_NEWLINE);
   assign do_load = accept && (req_action == ACT_LOAD) && !skip;
   assign do_read = accept && (req_action == ACT_READ) && loaded_ff;

   assign n1 = OW'(side_ff) - OW'(1);
   assign dim = (view_ff == VIEW_DIAMOND) ? (n1 << 1) + OW'(1) : OW'(side_ff);

   always_comb begin
      if (out_row_ff >= dim || out_col_ff >= dim) begin
         cur_r = '0;
         cur_c = '0;
      end else begin
         cur_r = out_row_ff;
         cur_c = out_col_ff;
      end
   end

   assign da = $signed(DW'(cur_r)) + $signed(DW'(cur_c)) - $signed(DW'(n1));
   assign db = $signed(DW'(cur_r)) - $signed(DW'(cur_c)) + $signed(DW'(n1));
   assign ha = da[DW-1:1];
   assign hb = db[DW-1:1];

   always_comb begin
      blank = 1'b0;
      unique case (view_ff)
         VIEW_ORIG: begin
            pr = CW'(cur_r);
            pc = CW'(cur_c);
         end
         VIEW_ROT90: begin
            pr = CW'(n1 - cur_c);
            pc = CW'(cur_r);
         end
         VIEW_ROT270: begin
            pr = CW'(cur_c);
            pc = CW'(n1 - cur_r);
         end
         default: begin
            pr = CW'(hb);
            pc = CW'(ha);
            blank = da[DW-1] || db[DW-1] || da[0]
               || (ha >= (DW-1)'(side_ff)) || (hb >= (DW-1)'(side_ff));
         end
      endcase
   end

   assign rd_addr = AW'(pr) * AW'(MAX_SIDE) + AW'(pc);
   assign wr_addr = AW'(load_row_ff) * AW'(MAX_SIDE) + AW'(load_col_ff);

   assign ctl.wr_en = do_load;
   assign ctl.rd_en = do_read;
   assign ctl.blank = blank;
   assign ctl.row_end = (cur_c == dim - OW'(1));
   assign ctl.img_end = (cur_c == dim - OW'(1)) && (cur_r == dim - OW'(1));

   always_comb begin
      if (csr_wdata < SIDE_W'(MIN_SIDE)) begin
         side_wr = SIDE_W'(MIN_SIDE);
      end else if (32'(csr_wdata) > MAX_SIDE) begin
         side_wr = SIDE_W'(MAX_SIDE);
      end else begin
         side_wr = csr_wdata;
      end
   end

   always_comb begin
      side_in = side_ff;
      view_in = view_ff;
      loaded_in = loaded_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (do_load) begin
         if (32'(load_col_ff) + 1 >= 32'(side_ff)) begin
            load_col_in = '0;
            if (32'(load_row_ff) + 1 >= 32'(side_ff)) begin
               load_row_in = '0;
               loaded_in = 1'b1;
            end else begin
               load_row_in = load_row_ff + CW'(1);
            end
         end else begin
            load_col_in = load_col_ff + CW'(1);
         end
      end
      if (do_read) begin
         if (cur_c == dim - OW'(1)) begin
            out_col_in = '0;
            out_row_in = (cur_r == dim - OW'(1)) ? '0 : cur_r + OW'(1);
         end else begin
            out_col_in = cur_c + OW'(1);
            out_row_in = cur_r;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            REG_SIDE: begin
               side_in = side_wr;
               loaded_in = 1'b0;
               load_row_in = '0;
               load_col_in = '0;
               out_row_in = '0;
               out_col_in = '0;
            end
            default: begin
               view_in = csr_wdata[1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(RESET_SIDE);
         view_ff <= VIEW_ORIG;
         loaded_ff <= 1'b0;
         load_row_ff <= '0;
         load_col_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         side_ff <= side_in;
         view_ff <= view_in;
         loaded_ff <= loaded_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

endmodule

// ===== hw/rtl/square_image_rotator.sv =====
// Top level of the square image rotator: controller, pixel memory and result register.
// Depends on sqr_rot_pkg, sqr_rot_ctrl, sqr_rot_mem and assert_macros.svh.
//
//   Channel   Ports                              Handshake
//   request   start, busy, req_action, req_pixel_in   start && !busy
//   response  rsp_valid, rsp_pixel_out, rsp_row_end, rsp_image_end   strobe
//   csr       csr_we, csr_index, csr_wdata       write enable
//
// One beat is taken every cycle; busy stays low.
// A read beat of a loaded image is answered through the registered memory read port.
// A load beat other than a space or newline writes memory when taken; no result.
// Reset restores side 2 and the original view and empties the image; no clearing pass.
`include "assert_macros.svh"

module square_image_rotator import sqr_rot_pkg::*; #(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  logic [PIX_W-1:0]  req_pixel_in,
   output logic              rsp_valid,
   output logic [PIX_W-1:0]  rsp_pixel_out,
   output logic              rsp_row_end,
   output logic              rsp_image_end,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

   mem_ctl_type      ctl;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             accept;
   logic             valid_ff, blank_ff, row_end_ff, img_end_ff;

   assign busy = 1'b0;
   assign accept = start && !busy;

   sqr_rot_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_action   (req_action),
      .req_pixel_in (req_pixel_in),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctl          (ctl),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr)
   );

   sqr_rot_mem #(.MAX_SIDE(MAX_SIDE)) u_mem (
      .clock   (clock),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         blank_ff <= ctl.blank;
         row_end_ff <= ctl.row_end;
         img_end_ff <= ctl.img_end;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pixel_out = blank_ff ? CHAR_SPACE : rd_data;
   assign rsp_row_end = row_end_ff;
   assign rsp_image_end = img_end_ff;

   `ASSERT_CLK(a_rsp_follows_read, rsp_valid |-> $past(accept && req_action == ACT_READ), "result beat without a read beat")
   `ASSERT_NEVER_BOTH(a_no_rd_wr_same_cycle, ctl.wr_en, ctl.rd_en, "memory read and write in one cycle")
   `ASSERT_CLK(a_image_end_ends_row, (rsp_valid && rsp_image_end) |-> rsp_row_end, "image end off a row end")

endmodule
